// ===== sv/pnt_pkg.sv =====
// ----------------------------------------------------------------------------
// Perfect number test - shared package
// Widths and sequencer state type for the aliquot sum unit.
// ----------------------------------------------------------------------------
package pnt_pkg;

   // default input width and fixed result width
   localparam int unsigned PNT_WIDTH = 16;
   localparam int unsigned PNT_SUM_W = 20;
   // headroom bits on the running divisor total (sigma(n) < 16 n below 2^32)
   localparam int unsigned PNT_GUARD = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_ACCUM,
      ST_FINAL
   } pnt_state_type;

endpackage

// ===== sv/pnt_req_if.sv =====
// ----------------------------------------------------------------------------
// Perfect number test - request channel
// Valid/ready channel carrying the number to test.
// ----------------------------------------------------------------------------
interface pnt_req_if
   import pnt_pkg::*;
#(
   parameter int unsigned WIDTH = PNT_WIDTH
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] number_in;

   modport source (output valid, output number_in, input ready);
   modport sink   (input valid, input number_in, output ready);
endinterface

// ===== sv/pnt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Perfect number test - response channel
// Valid/ready channel carrying the divisor sum and the perfect flag.
// ----------------------------------------------------------------------------
interface pnt_rsp_if
   import pnt_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [PNT_SUM_W-1:0] divisor_sum;
   logic                 is_perfect;

   modport source (output valid, output divisor_sum, output is_perfect, input ready);
   modport sink   (input valid, input divisor_sum, input is_perfect, output ready);
endinterface

// ===== sv/perfect_number_test_unit.sv =====
// ----------------------------------------------------------------------------
// Perfect number test unit
// Aliquot sum of one number per transfer, plus a flag for perfect numbers.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan (sink) takes one number per transfer (valid and ready high at
//   a rising edge). rsp_chan (source) returns one transfer per number: the
//   sum of its proper divisors and is_perfect.
//   The unit trials every divisor d from 1 while d <= n/d; each trial starts
//   the shared restoring divider, waits for it in the divide step and then
//   adds the divisor pair in the accumulate step when d divides n.
//   req_chan.ready is high only in the idle state; the unit works on one
//   number at a time. A number may be taken while the previous result still
//   waits in the output register; if the receiver stalls, the next result
//   holds in the final step until the output register is free.
//   Reset is synchronous and active high; it returns the sequencer to idle
//   and drops rsp_chan.valid. No state is kept between numbers.
// ----------------------------------------------------------------------------
module perfect_number_test_unit
   import pnt_pkg::*;
#(
   parameter int unsigned WIDTH = PNT_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   pnt_req_if.sink   req_chan,
   pnt_rsp_if.source rsp_chan
);
   localparam int unsigned TOT_W = WIDTH + PNT_GUARD;

   pnt_state_type    state_ff, state_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PNT_SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic             rsp_perf_ff, rsp_perf_in;

   logic             req_ready;
   logic             div_start;
   logic             rsp_load;
   logic             out_free;
   logic             div_done;
   logic [WIDTH-1:0] div_quo;
   logic [WIDTH-1:0] div_rem;
   logic             trial_ok;
   logic [TOT_W-1:0] pair_sum;
   logic [TOT_W-1:0] aliquot;

   // shared divider: n / d and n % d
   pnt_div #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign trial_ok = (d_ff <= div_quo);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pair_sum = TOT_W'(d_ff) + ((div_quo != d_ff) ? TOT_W'(div_quo) : '0);
   assign aliquot  = total_ff - TOT_W'(n_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_chan.valid) state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_done) state_in = ST_ACCUM;
         ST_ACCUM:  state_in = trial_ok ? ST_LAUNCH : ST_FINAL;
         ST_FINAL:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_LAUNCH: div_start = 1'b1;
         ST_FINAL:  rsp_load  = out_free;
         default:   ;
      endcase
   end

   // datapath: load the number, accumulate divisor pairs, form the result
   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_perf_in  = rsp_perf_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_ready && req_chan.valid) begin
         n_in     = req_chan.number_in;
         d_in     = WIDTH'(1);
         total_in = '0;
      end
      if (state_ff == ST_ACCUM && trial_ok) begin
         if (div_rem == '0) begin
            total_in = total_ff + pair_sum;
         end
         d_in = d_ff + WIDTH'(1);
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = PNT_SUM_W'(aliquot);
         rsp_perf_in  = (n_ff != '0) && (aliquot == TOT_W'(n_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff       <= n_in;
      d_ff       <= d_in;
      total_ff   <= total_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_perf_ff <= rsp_perf_in;
   end

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.divisor_sum = rsp_sum_ff;
   assign rsp_chan.is_perfect  = rsp_perf_ff;

   // an accepted number always launches a first division
   a_accept_launch: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_ready |=> state_ff == ST_LAUNCH)
      else $error("accepted number did not launch a division");

   // the divider only reports completion while the sequencer waits on it
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider completion outside the divide step");

   // the trial divisor is never zero while a number is in work
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE || state_ff == ST_ACCUM |-> d_ff != '0)
      else $error("zero trial divisor");

   // a free output register takes the result and the unit goes idle
   a_final_release: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("final result not released");

endmodule

// ===== sv/pnt_div.sv =====
// ----------------------------------------------------------------------------
// Perfect number test - iterative divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pnt_div
   import pnt_pkg::*;
#(
   parameter int unsigned WIDTH = PNT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   localparam int unsigned CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   // trial subtract of the divisor from the shifted partial remainder
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, divisor};

   // advance one quotient bit per cycle while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
         rem_in = diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== tb/sv/perfect_number_test_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Perfect number test unit - testbench
// Drives a table of chosen numbers, then random ones, into the request
// channel and compares every response with the literal response of its
// table row or with a local aliquot sum predictor. Both channels idle at
// random. The receiver also holds off once for a long stretch so that the
// unit backs up and stalls its input.
module perfect_number_test_unit_tb
   import pnt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TB_WIDTH        = PNT_WIDTH;
   localparam int          RANDOM_ITEMS    = 76;
   localparam int          PROBE_ROWS      = 24;
   localparam int          PRESSURE_CYCLES = 20000;
   localparam int          DRAIN_LIMIT     = 40000;
   localparam int          TAIL_CYCLES     = 6000;
   localparam int          REPORT_LIMIT    = 10;

   // expected response for one transfer
   typedef struct packed {
      logic [15:0]          number;
      logic [PNT_SUM_W-1:0] divisor_sum;
      logic                 is_perfect;
   } aliquot_result_type;

   // stimulus table row; typed rows carry a literal response
   typedef struct packed {
      logic [15:0]          number;
      logic                 typed;
      logic [PNT_SUM_W-1:0] divisor_sum;
      logic                 is_perfect;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset;

   pnt_req_if #(.WIDTH(TB_WIDTH)) req_bus ();
   pnt_rsp_if                     rsp_bus ();

   perfect_number_test_unit #(.WIDTH(TB_WIDTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   aliquot_result_type pending_results[$];
   int              fault_count        = 0;
   int              results_seen       = 0;
   int              perfect_seen       = 0;
   int              numbers_sent       = 0;
   int              input_stall_cycles = 0;
   bit              result_decided     = 1'b0;
   bit              pressure_done      = 1'b0;

   probe_row_type probe_table [PROBE_ROWS] = '{
      '{16'd1,     1'b1, 20'd0,     1'b0},
      '{16'd0,     1'b1, 20'd0,     1'b0},
      '{16'd2,     1'b1, 20'd1,     1'b0},
      '{16'd3,     1'b0, 20'd0,     1'b0},
      '{16'd4,     1'b1, 20'd3,     1'b0},
      '{16'd6,     1'b1, 20'd6,     1'b1},
      '{16'd9,     1'b1, 20'd4,     1'b0},
      '{16'd12,    1'b1, 20'd16,    1'b0},
      '{16'd28,    1'b1, 20'd28,    1'b1},
      '{16'd36,    1'b0, 20'd0,     1'b0},
      '{16'd496,   1'b1, 20'd496,   1'b1},
      '{16'd8128,  1'b1, 20'd8128,  1'b1},
      '{16'd8127,  1'b0, 20'd0,     1'b0},
      '{16'd8129,  1'b0, 20'd0,     1'b0},
      '{16'd720,   1'b0, 20'd0,     1'b0},
      '{16'd1024,  1'b1, 20'd1023,  1'b0},
      '{16'd32767, 1'b0, 20'd0,     1'b0},
      '{16'd32768, 1'b1, 20'd32767, 1'b0},
      '{16'd21845, 1'b0, 20'd0,     1'b0},
      '{16'd43690, 1'b0, 20'd0,     1'b0},
      '{16'd65521, 1'b1, 20'd1,     1'b0},
      '{16'd65534, 1'b0, 20'd0,     1'b0},
      '{16'd65535, 1'b0, 20'd0,     1'b0},
      '{16'd45360, 1'b0, 20'd0,     1'b0}
   };

   // sum of proper divisors, wrapped to the result field
   function automatic aliquot_result_type predict_aliquot(input logic [15:0] number);
      longint unsigned n;
      longint unsigned total;
      longint unsigned d;
      longint unsigned q;
      aliquot_result_type result;
      n     = longint'(number) & ((64'd1 << TB_WIDTH) - 64'd1);
      total = 0;
      if (n != 0) begin
         // pair each divisor up to the square root with its cofactor
         for (d = 1; d <= n / d; d++) begin
            if (n % d == 0) begin
               q     = n / d;
               total = total + d;
               if (q != d) begin
                  total = total + q;
               end
            end
         end
         total = total - n;
      end
      result.number      = number;
      result.divisor_sum = total[PNT_SUM_W-1:0];
      result.is_perfect  = (n != 0) && (total == n);
      return result;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 16);
      end
      return $urandom_range(40, 200);
   endfunction

   // mostly small numbers to keep the divider loop short
   function automatic logic [15:0] pick_number();
      int          r;
      logic [15:0] near;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return 16'($urandom_range(1, 1023));
      end else if (r < 85) begin
         case ($urandom_range(0, 3))
            0: near = 16'd6;
            1: near = 16'd28;
            2: near = 16'd496;
            default: near = 16'd8128;
         endcase
         return 16'(int'(near) + $urandom_range(0, 2) - 1);
      end
      return 16'($urandom_range(1, 65535));
   endfunction

   // offer one number, called at a falling edge; returns at a falling edge
   task automatic offer_number(input logic [15:0] number, input logic typed,
                               input aliquot_result_type literal);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid     <= 1'b0;
         req_bus.number_in <= 16'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.number_in <= number;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      if (typed) begin
         pending_results.push_back(literal);
      end else begin
         pending_results.push_back(predict_aliquot(number));
      end
      numbers_sent++;
      @(negedge clock);
   endtask

   always #2 clock = ~clock;

   // receiver: random hold-offs per response, one long stall after the table
   initial begin
      int hold;
      hold          = 0;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!pressure_done && results_seen >= PROBE_ROWS + 3) begin
            pressure_done = 1'b1;
            hold          = PRESSURE_CYCLES;
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else if (rsp_bus.valid && !result_decided) begin
            result_decided = 1'b1;
            hold           = pick_gap();
            if (hold > 0) begin
               rsp_bus.ready <= 1'b0;
               hold--;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // compare each response transfer with the oldest expectation
   initial begin
      aliquot_result_type want;
      forever begin
         @(posedge clock);
         if (reset) begin
            continue;
         end
         if (req_bus.valid && !req_bus.ready) begin
            input_stall_cycles++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_decided = 1'b0;
            results_seen++;
            if (rsp_bus.is_perfect) begin
               perfect_seen++;
            end
            if (pending_results.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("unexpected response: sum %0d perfect %0b",
                           rsp_bus.divisor_sum, rsp_bus.is_perfect);
               end
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.divisor_sum !== want.divisor_sum ||
                   rsp_bus.is_perfect !== want.is_perfect) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display({"mismatch for %0d: expected sum %0d perfect %0b,",
                               " got sum %0d perfect %0b"},
                              want.number, want.divisor_sum, want.is_perfect,
                              rsp_bus.divisor_sum, rsp_bus.is_perfect);
                  end
               end
            end
         end
      end
   end

   // end the run if it hangs
   initial begin
      #15_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // reset, table, random numbers, drain
   initial begin
      int              i;
      int              waited;
      aliquot_result_type literal;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.number_in = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // walk the table
      for (i = 0; i < PROBE_ROWS; i++) begin
         literal.number      = probe_table[i].number;
         literal.divisor_sum = probe_table[i].divisor_sum;
         literal.is_perfect  = probe_table[i].is_perfect;
         offer_number(probe_table[i].number, probe_table[i].typed, literal);
      end

      // random numbers
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         offer_number(pick_number(), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      // wait for outstanding responses, then let the pipeline settle
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         fault_count += pending_results.size();
         $display("%0d responses never arrived", pending_results.size());
      end

      $display("covered %0d numbers (%0d table rows, %0d random), %0d perfect",
               numbers_sent, PROBE_ROWS, RANDOM_ITEMS, perfect_seen);
      $display("input held off for %0d cycles by back-pressure; %0d faults",
               input_stall_cycles, fault_count);
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
